/* design/dra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types and codes for the DNS reply A-record parser.
// ----------------------------------------------------------------------------
package dra_pkg;

	// one byte of the reply message
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	// one verdict per message
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  response_code;
		logic [31:0] address;
		logic [31:0] time_to_live;
	} verdict_item_t;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_SHORT    = 3'd1,
		ST_NOT_RESP = 3'd2,
		ST_RCODE    = 3'd3,
		ST_TRUNC    = 3'd4,
		ST_NO_A     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'd0,
		PH_QNAME  = 4'd1,
		PH_QPTR   = 4'd2,
		PH_QTAIL  = 4'd3,
		PH_ANAME  = 4'd4,
		PH_APTR   = 4'd5,
		PH_AFIXED = 4'd6,
		PH_ADATA  = 4'd7,
		PH_DONE   = 4'd8
	} phase_t;

	localparam logic [3:0]  HEADER_LAST_IDX = 4'd11;
	localparam logic [3:0]  QTAIL_LAST_IDX  = 4'd3;
	localparam logic [3:0]  AFIXED_LAST_IDX = 4'd9;
	localparam logic [15:0] FLAG_RESPONSE   = 16'h8000;
	localparam logic [15:0] FLAG_RCODE      = 16'h000F;
	localparam logic [1:0]  PTR_MARK        = 2'b11;
	localparam logic [15:0] TYPE_A          = 16'd1;
	localparam logic [15:0] CLASS_IN        = 16'd1;
	localparam logic [15:0] A_DATA_LEN      = 16'd4;

endpackage
`default_nettype wire

/* design/dra_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_parser
// Per-byte parse state and its next-state logic; forms the verdict on the
// final byte and returns to the header phase after it.
// ----------------------------------------------------------------------------
module dra_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  dra_pkg::byte_item_t    item,
	output dra_pkg::verdict_item_t result
);
	import dra_pkg::*;

	phase_t      phase_q,      phase_n;
	logic [3:0]  idx_q,        idx_n;
	logic [15:0] flags_q,      flags_n;
	logic [15:0] qleft_q,      qleft_n;
	logic [15:0] aleft_q,      aleft_n;
	logic [7:0]  label_q,      label_n;
	logic [15:0] rtype_q,      rtype_n;
	logic [15:0] rclass_q,     rclass_n;
	logic [31:0] ttl_q,        ttl_n;
	logic [15:0] dleft_q,      dleft_n;
	logic [31:0] addr_q,       addr_n;
	status_t     verdict_q,    verdict_n;
	logic [7:0]  b;
	logic        name_end;
	logic [15:0] cnt_dec;
	status_t     st;

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		flags_n   = flags_q;
		qleft_n   = qleft_q;
		aleft_n   = aleft_q;
		label_n   = label_q;
		rtype_n   = rtype_q;
		rclass_n  = rclass_q;
		ttl_n     = ttl_q;
		dleft_n   = dleft_q;
		addr_n    = addr_q;
		verdict_n = verdict_q;
		b         = item.data_byte;
		name_end  = 1'b0;
		cnt_dec   = '0;

		unique case (phase_q)
			PH_HEADER: begin
				case (idx_q)
					4'd2: flags_n[15:8] = b;
					4'd3: flags_n[7:0]  = b;
					4'd4: qleft_n[15:8] = b;
					4'd5: qleft_n[7:0]  = b;
					4'd6: aleft_n[15:8] = b;
					4'd7: aleft_n[7:0]  = b;
					default: ;
				endcase
				idx_n = idx_q + 4'd1;
				if (idx_q == HEADER_LAST_IDX) begin
					idx_n   = '0;
					label_n = '0;
					if ((flags_n & FLAG_RESPONSE) == '0) begin
						verdict_n = ST_NOT_RESP;
						phase_n   = PH_DONE;
					end else if ((flags_n & FLAG_RCODE) != '0) begin
						verdict_n = ST_RCODE;
						phase_n   = PH_DONE;
					end else if (qleft_n != '0) begin
						phase_n = PH_QNAME;
					end else if (aleft_n == '0) begin
						verdict_n = ST_NO_A;
						phase_n   = PH_DONE;
					end else begin
						phase_n = PH_ANAME;
					end
				end
			end
			PH_QNAME, PH_ANAME: begin
				if (label_q != '0) begin
					label_n = label_q - 8'd1;
				end else if (b[7:6] == PTR_MARK) begin
					phase_n = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
				end else if (b == '0) begin
					name_end = 1'b1;
				end else begin
					label_n = b;
				end
				if (name_end) begin
					phase_n = (phase_q == PH_QNAME) ? PH_QTAIL : PH_AFIXED;
					idx_n   = '0;
				end
			end
			PH_QPTR: begin
				phase_n = PH_QTAIL;
				idx_n   = '0;
			end
			PH_APTR: begin
				phase_n = PH_AFIXED;
				idx_n   = '0;
			end
			PH_QTAIL: begin
				idx_n = idx_q + 4'd1;
				if (idx_q == QTAIL_LAST_IDX) begin
					cnt_dec = qleft_q - 16'd1;
					qleft_n = cnt_dec;
					idx_n   = '0;
					label_n = '0;
					if (cnt_dec != '0) begin
						phase_n = PH_QNAME;
					end else if (aleft_q == '0) begin
						verdict_n = ST_NO_A;
						phase_n   = PH_DONE;
					end else begin
						phase_n = PH_ANAME;
					end
				end
			end
			PH_AFIXED: begin
				if (idx_q < 4'd2) begin
					rtype_n = {rtype_q[7:0], b};
				end else if (idx_q < 4'd4) begin
					rclass_n = {rclass_q[7:0], b};
				end else if (idx_q < 4'd8) begin
					ttl_n = {ttl_q[23:0], b};
				end else begin
					dleft_n = {dleft_q[7:0], b};
				end
				idx_n = idx_q + 4'd1;
				if (idx_q == AFIXED_LAST_IDX) begin
					idx_n = '0;
					// anything but a plain IPv4 record has its data skipped
					if (!(rtype_n == TYPE_A && rclass_n == CLASS_IN &&
					      dleft_n == A_DATA_LEN)) begin
						rtype_n = '0;
					end
					if (dleft_n == '0) begin
						cnt_dec = aleft_q - 16'd1;
						aleft_n = cnt_dec;
						label_n = '0;
						if (cnt_dec == '0) begin
							verdict_n = ST_NO_A;
							phase_n   = PH_DONE;
						end else begin
							phase_n = PH_ANAME;
						end
					end else begin
						phase_n = PH_ADATA;
						addr_n  = '0;
					end
				end
			end
			PH_ADATA: begin
				if (rtype_q == TYPE_A) begin
					addr_n = {addr_q[23:0], b};
				end
				dleft_n = dleft_q - 16'd1;
				if (dleft_n == '0) begin
					if (rtype_q == TYPE_A) begin
						verdict_n = ST_FOUND;
						phase_n   = PH_DONE;
					end else begin
						cnt_dec = aleft_q - 16'd1;
						aleft_n = cnt_dec;
						idx_n   = '0;
						label_n = '0;
						if (cnt_dec == '0) begin
							verdict_n = ST_NO_A;
							phase_n   = PH_DONE;
						end else begin
							phase_n = PH_ANAME;
						end
					end
				end
			end
			default: ;
		endcase

		// verdict as seen after this byte
		if (phase_n == PH_HEADER) begin
			st                   = ST_SHORT;
			result.response_code = '0;
		end else begin
			st                   = (phase_n == PH_DONE) ? verdict_n : ST_TRUNC;
			result.response_code = flags_n[3:0];
		end
		result.status       = st;
		result.address      = (st == ST_FOUND) ? addr_n : '0;
		result.time_to_live = (st == ST_FOUND) ? ttl_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			idx_q     <= '0;
			flags_q   <= '0;
			qleft_q   <= '0;
			aleft_q   <= '0;
			label_q   <= '0;
			rtype_q   <= '0;
			rclass_q  <= '0;
			ttl_q     <= '0;
			dleft_q   <= '0;
			addr_q    <= '0;
			verdict_q <= ST_TRUNC;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q   <= PH_HEADER;
				idx_q     <= '0;
				flags_q   <= '0;
				qleft_q   <= '0;
				aleft_q   <= '0;
				label_q   <= '0;
				rtype_q   <= '0;
				rclass_q  <= '0;
				ttl_q     <= '0;
				dleft_q   <= '0;
				addr_q    <= '0;
				verdict_q <= ST_TRUNC;
			end else begin
				phase_q   <= phase_n;
				idx_q     <= idx_n;
				flags_q   <= flags_n;
				qleft_q   <= qleft_n;
				aleft_q   <= aleft_n;
				label_q   <= label_n;
				rtype_q   <= rtype_n;
				rclass_q  <= rclass_n;
				ttl_q     <= ttl_n;
				dleft_q   <= dleft_n;
				addr_q    <= addr_n;
				verdict_q <= verdict_n;
			end
		end
	end

endmodule
`default_nettype wire

/* design/dra_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_out_reg
// Verdict holding register on the output channel.
// ----------------------------------------------------------------------------
module dra_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  dra_pkg::verdict_item_t load_item,
	output logic                   free,
	output logic                   valid,
	input  logic                   stall,
	output dra_pkg::verdict_item_t item
);
	import dra_pkg::*;

	logic          valid_q;
	verdict_item_t item_q;

	// slot opens when empty or when the held verdict transfers this cycle
	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= load_item;
		end
	end

endmodule
`default_nettype wire

/* design/dns_reply_a_record_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_reply_a_record_parser
// Parses a DNS reply byte stream and reports the first A record per message.
// ----------------------------------------------------------------------------
// usage
//  - byte channel (byte_valid / byte_stall / byte_item): one message byte per
//    transfer, last_byte set on the final byte of each message
//  - verdict channel (verdict_valid / verdict_stall / verdict_item): exactly
//    one verdict per message, produced by its final byte
//  - a byte is registered at its transfer and then walked through the parse
//    logic; the verdict of the final byte is loaded into the verdict register
//    and shows on verdict_valid from there
//  - throughput is one byte per cycle while no final byte waits for the slot
//  - a held verdict does not block bytes that produce no verdict; only a
//    final byte waits for the verdict slot, and byte_stall rises then
//  - reset empties both registers and puts the parser in the header phase;
//    after each final byte the parser returns to the header phase by itself
// ----------------------------------------------------------------------------
module dns_reply_a_record_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  dra_pkg::byte_item_t    byte_item,
	output logic                   verdict_valid,
	input  logic                   verdict_stall,
	output dra_pkg::verdict_item_t verdict_item
);
	import dra_pkg::*;

	logic          valid_s1;
	byte_item_t    item_s1;
	logic          slot_free;
	logic          advance;
	verdict_item_t result;

	// a final byte needs the verdict slot, other bytes always move on
	assign advance    = valid_s1 && (!item_s1.last_byte || slot_free);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	dra_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	dra_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && item_s1.last_byte),
		.load_item (result),
		.free      (slot_free),
		.valid     (verdict_valid),
		.stall     (verdict_stall),
		.item      (verdict_item)
	);

endmodule
`default_nettype wire
